>>> rtl/sparse_polynomial_arith_assert.svh
// Assertion macros for the sparse polynomial arithmetic block.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SPARSE_POLYNOMIAL_ARITH_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ARITH_ASSERT_SVH
`ifndef SYNTHESIS
`define SPA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sparse_polynomial_arith: property violated");
`define SPA_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sparse_polynomial_arith: forbidden condition");
`else
`define SPA_ASSERT(lbl, clk, rst, prop)
`define SPA_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> rtl/spa_pkg.sv
// Shared types and constants of the sparse polynomial arithmetic block.
// No dependencies.
package spa_pkg;
   localparam int unsigned COEF_W  = 16;
   localparam int unsigned EXP_W   = 8;
   localparam int unsigned RCOEF_W = 32;
   localparam int unsigned REXP_W  = 9;
   localparam int unsigned ENTRY_W = RCOEF_W + REXP_W;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   typedef struct packed {
      logic load;
      logic init;
      logic add_step;
      logic commit;
      logic prod;
      logic mg_step;
      logic pair_next;
      logic out_rd;
      logic out_next;
      logic emit;
      logic clear;
   } spa_cmd_type;

   typedef struct packed {
      logic complete;
      logic mul;
      logic add_done;
      logic mg_done;
      logic pairs_done;
      logic out_last;
   } spa_stat_type;
endpackage

>>> rtl/spa_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module spa_ram #(
   parameter int unsigned WIDTH = 41,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/spa_ctrl.sv
// Controller state machine of the sparse polynomial arithmetic block.
// Depends on spa_pkg for the command and status structs.
module spa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  spa_pkg::spa_stat_type stat,
   output spa_pkg::spa_cmd_type  cmd,
   output logic                  busy
);
   import spa_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ADD   = 7'b0000010,
      S_MPROD = 7'b0000100,
      S_MRD   = 7'b0001000,
      S_MMG   = 7'b0010000,
      S_ORD   = 7'b0100000,
      S_OEMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            if (start && stat.complete) begin
               cmd.init = 1'b1;
               state_in = stat.mul ? S_MPROD : S_ADD;
            end
         end
         S_ADD: begin
            if (stat.add_done) begin
               cmd.commit = 1'b1;
               state_in   = S_ORD;
            end else begin
               cmd.add_step = 1'b1;
            end
         end
         S_MPROD: begin
            if (stat.pairs_done) begin
               state_in = S_ORD;
            end else begin
               cmd.prod = 1'b1;
               state_in = S_MRD;
            end
         end
         S_MRD: begin
            if (stat.mg_done) begin
               cmd.commit    = 1'b1;
               cmd.pair_next = 1'b1;
               state_in      = S_MPROD;
            end else begin
               state_in = S_MMG;
            end
         end
         S_MMG: begin
            cmd.mg_step = 1'b1;
            state_in    = S_MRD;
         end
         S_ORD: begin
            cmd.out_rd = 1'b1;
            state_in   = S_OEMIT;
         end
         S_OEMIT: begin
            cmd.emit = 1'b1;
            if (stat.out_last) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cmd.out_next = 1'b1;
               state_in     = S_ORD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule

>>> rtl/spa_datapath.sv
// Datapath: term stores, merge and multiply unit, result list RAMs.
// Depends on spa_pkg and spa_ram.
module spa_datapath #(
   parameter int unsigned MAX_TERMS        = 8,
   parameter int unsigned MAX_RESULT_TERMS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spa_pkg::spa_cmd_type         cmd,
   output spa_pkg::spa_stat_type        stat,
   input  logic                         csr_valid,
   input  logic [1:0]                   csr_wdata,
   input  logic                         req_operand_b,
   input  logic signed [15:0]           req_term_coef,
   input  logic [7:0]                   req_term_exponent,
   input  logic                         req_last_term,
   output logic signed [31:0]           rsp_result_coef,
   output logic [8:0]                   rsp_result_exponent,
   output logic                         rsp_result_last,
   output logic                         rsp_result_empty,
   output logic                         rsp_overflow,
   output logic                         rsp_status
);
   import spa_pkg::*;

   localparam int unsigned TAW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int unsigned TCW = $clog2(MAX_TERMS + 1);
   localparam int unsigned AW  = (MAX_RESULT_TERMS > 1) ? $clog2(MAX_RESULT_TERMS) : 1;
   localparam int unsigned CW  = $clog2(MAX_RESULT_TERMS + 1);

   logic [1:0]                op_ff;
   logic signed [COEF_W-1:0]  a_coef_ff [MAX_TERMS];
   logic [EXP_W-1:0]          a_exp_ff  [MAX_TERMS];
   logic signed [COEF_W-1:0]  b_coef_ff [MAX_TERMS];
   logic [EXP_W-1:0]          b_exp_ff  [MAX_TERMS];
   logic [TCW-1:0]            na_ff, nb_ff, ai_ff, bj_ff;
   logic                      a_done_ff, b_done_ff, drop_ff, ovf_ff;
   logic                      sel_ff, pv_ff;
   logic signed [RCOEF_W-1:0] p_coef_ff;
   logic [REXP_W-1:0]         p_exp_ff;
   logic [CW-1:0]             n_ff, wcnt_ff, mj_ff, k_ff;

   logic signed [COEF_W-1:0]  a_c, b_c;
   logic [EXP_W-1:0]          a_e, b_e;
   logic signed [COEF_W:0]    b_q, sum17;
   logic signed [RCOEF_W:0]   sum33;
   logic [ENTRY_W-1:0]        rd0, rd1, rd;
   logic signed [RCOEF_W-1:0] q_c;
   logic [REXP_W-1:0]         q_e;
   logic                      a_has, b_has, q_has;
   logic                      push_en, wr_en, ovf_set, ai_inc, bj_inc, mj_inc, p_clr;
   logic [RCOEF_W-1:0]        push_c;
   logic [REXP_W-1:0]         push_e;
   logic [AW-1:0]             raddr;
   logic                      ld_drop, ld_done_a, ld_done_b;

   assign a_c   = a_coef_ff[ai_ff[TAW-1:0]];
   assign a_e   = a_exp_ff[ai_ff[TAW-1:0]];
   assign b_c   = b_coef_ff[bj_ff[TAW-1:0]];
   assign b_e   = b_exp_ff[bj_ff[TAW-1:0]];
   assign b_q   = (op_ff == OP_SUB) ? -(COEF_W+1)'(b_c) : (COEF_W+1)'(b_c);
   assign sum17 = (COEF_W+1)'(a_c) + b_q;
   assign rd    = sel_ff ? rd1 : rd0;
   assign q_c   = rd[ENTRY_W-1:REXP_W];
   assign q_e   = rd[REXP_W-1:0];
   assign sum33 = (RCOEF_W+1)'(p_coef_ff) + (RCOEF_W+1)'(q_c);
   assign a_has = ai_ff < na_ff;
   assign b_has = bj_ff < nb_ff;
   assign q_has = mj_ff < n_ff;

   always_comb begin
      push_en = 1'b0;
      push_c  = '0;
      push_e  = '0;
      ovf_set = 1'b0;
      ai_inc  = 1'b0;
      bj_inc  = 1'b0;
      mj_inc  = 1'b0;
      p_clr   = 1'b0;
      if (cmd.add_step) begin
         if (a_has && b_has && (a_e == b_e)) begin
            ai_inc  = 1'b1;
            bj_inc  = 1'b1;
            push_en = (sum17 != '0);
            push_c  = RCOEF_W'(sum17);
            push_e  = {1'b0, a_e};
         end else if (a_has && (!b_has || (a_e > b_e))) begin
            ai_inc  = 1'b1;
            push_en = 1'b1;
            push_c  = RCOEF_W'(a_c);
            push_e  = {1'b0, a_e};
         end else if (b_has) begin
            bj_inc  = 1'b1;
            push_en = 1'b1;
            push_c  = RCOEF_W'(b_q);
            push_e  = {1'b0, b_e};
         end
      end
      if (cmd.mg_step) begin
         if (pv_ff && q_has && (p_exp_ff == q_e)) begin
            p_clr   = 1'b1;
            mj_inc  = 1'b1;
            ovf_set = sum33[RCOEF_W] ^ sum33[RCOEF_W-1];
            push_en = (sum33[RCOEF_W-1:0] != '0);
            push_c  = sum33[RCOEF_W-1:0];
            push_e  = p_exp_ff;
         end else if (pv_ff && (!q_has || (p_exp_ff > q_e))) begin
            p_clr   = 1'b1;
            push_en = 1'b1;
            push_c  = p_coef_ff;
            push_e  = p_exp_ff;
         end else if (q_has) begin
            mj_inc  = 1'b1;
            push_en = 1'b1;
            push_c  = q_c;
            push_e  = q_e;
         end
      end
   end

   assign wr_en = push_en && (wcnt_ff < CW'(MAX_RESULT_TERMS));

   assign ld_done_a = a_done_ff || (!req_operand_b && req_last_term);
   assign ld_done_b = b_done_ff || (req_operand_b && req_last_term);
   assign ld_drop   = req_operand_b ? (b_done_ff || (nb_ff >= TCW'(MAX_TERMS)))
                                    : (a_done_ff || (na_ff >= TCW'(MAX_TERMS)));

   assign raddr = cmd.out_rd ? k_ff[AW-1:0] : mj_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_ADD;
         na_ff     <= '0;
         nb_ff     <= '0;
         a_done_ff <= 1'b0;
         b_done_ff <= 1'b0;
         drop_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         sel_ff    <= 1'b0;
         pv_ff     <= 1'b0;
         ai_ff     <= '0;
         bj_ff     <= '0;
         n_ff      <= '0;
         wcnt_ff   <= '0;
         mj_ff     <= '0;
         k_ff      <= '0;
      end else begin
         if (csr_valid) begin
            op_ff <= csr_wdata;
         end
         if (cmd.load) begin
            if (ld_drop) begin
               drop_ff <= 1'b1;
            end
            if (req_operand_b) begin
               if (!b_done_ff) begin
                  if (nb_ff < TCW'(MAX_TERMS)) begin
                     nb_ff <= nb_ff + TCW'(1);
                  end
                  b_done_ff <= req_last_term;
               end
            end else begin
               if (!a_done_ff) begin
                  if (na_ff < TCW'(MAX_TERMS)) begin
                     na_ff <= na_ff + TCW'(1);
                  end
                  a_done_ff <= req_last_term;
               end
            end
         end
         if (cmd.init) begin
            ovf_ff  <= 1'b0;
            sel_ff  <= 1'b0;
            n_ff    <= '0;
            wcnt_ff <= '0;
            ai_ff   <= '0;
            bj_ff   <= '0;
            k_ff    <= '0;
         end
         if (ai_inc) begin
            ai_ff <= ai_ff + TCW'(1);
         end
         if (bj_inc) begin
            bj_ff <= bj_ff + TCW'(1);
         end
         if (mj_inc) begin
            mj_ff <= mj_ff + CW'(1);
         end
         if (p_clr) begin
            pv_ff <= 1'b0;
         end
         if (ovf_set) begin
            ovf_ff <= 1'b1;
         end
         if (wr_en) begin
            wcnt_ff <= wcnt_ff + CW'(1);
         end else if (push_en) begin
            drop_ff <= 1'b1;
         end
         if (cmd.prod) begin
            pv_ff   <= 1'b1;
            mj_ff   <= '0;
            wcnt_ff <= '0;
         end
         if (cmd.commit) begin
            sel_ff <= !sel_ff;
            n_ff   <= wcnt_ff;
         end
         if (cmd.pair_next) begin
            if ((bj_ff + TCW'(1)) == nb_ff) begin
               bj_ff <= '0;
               ai_ff <= ai_ff + TCW'(1);
            end else begin
               bj_ff <= bj_ff + TCW'(1);
            end
         end
         if (cmd.out_next) begin
            k_ff <= k_ff + CW'(1);
         end
         if (cmd.clear) begin
            na_ff     <= '0;
            nb_ff     <= '0;
            a_done_ff <= 1'b0;
            b_done_ff <= 1'b0;
            drop_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (req_operand_b && !b_done_ff && (nb_ff < TCW'(MAX_TERMS))) begin
            b_coef_ff[nb_ff[TAW-1:0]] <= req_term_coef;
            b_exp_ff[nb_ff[TAW-1:0]]  <= req_term_exponent;
         end
         if (!req_operand_b && !a_done_ff && (na_ff < TCW'(MAX_TERMS))) begin
            a_coef_ff[na_ff[TAW-1:0]] <= req_term_coef;
            a_exp_ff[na_ff[TAW-1:0]]  <= req_term_exponent;
         end
      end
      if (cmd.prod) begin
         p_coef_ff <= RCOEF_W'(a_c * b_c);
         p_exp_ff  <= REXP_W'(a_e) + REXP_W'(b_e);
      end
   end

   spa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RESULT_TERMS)) u_ram0 (
      .clock (clock),
      .we    (wr_en && sel_ff),
      .waddr (wcnt_ff[AW-1:0]),
      .wdata ({push_c, push_e}),
      .raddr (raddr),
      .rdata (rd0)
   );

   spa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RESULT_TERMS)) u_ram1 (
      .clock (clock),
      .we    (wr_en && !sel_ff),
      .waddr (wcnt_ff[AW-1:0]),
      .wdata ({push_c, push_e}),
      .raddr (raddr),
      .rdata (rd1)
   );

   always_comb begin
      stat            = '0;
      stat.complete   = ld_done_a && ld_done_b;
      stat.mul        = op_ff[1];
      stat.add_done   = !a_has && !b_has;
      stat.mg_done    = !pv_ff && !q_has;
      stat.pairs_done = !a_has || (nb_ff == '0);
      stat.out_last   = (n_ff == '0) || ((k_ff + CW'(1)) == n_ff);
   end

   assign rsp_result_empty    = (n_ff == '0);
   assign rsp_result_coef     = rsp_result_empty ? '0 : q_c;
   assign rsp_result_exponent = rsp_result_empty ? '0 : q_e;
   assign rsp_result_last     = stat.out_last;
   assign rsp_overflow        = ovf_ff;
   assign rsp_status          = drop_ff;
endmodule

>>> rtl/sparse_polynomial_arith.sv
// Top level of the sparse polynomial arithmetic block.
// Depends on spa_pkg, spa_ctrl, spa_datapath and the assertion header.
//
// Terms of A and B load at one per cycle while busy is low. The term that
// completes both polynomials raises busy; the block then computes and
// emits results, each on the rsp_ ports for one cycle with rsp_strobe
// high, and busy falls after the last one. The receiver cannot stall.
// Add or subtract makes na+nb-m merge steps, where m is the number of
// matched exponents, and then commits the result. Multiply forms each of
// the na*nb term products in turn and merges it into a running result
// of length n in n+1 merge steps at most, n when the exponent matches,
// each step a read state then a merge state, and commits it: each
// insertion walks the result list through the registered read port of
// the ping-pong result RAMs.
// The operation register is written through csr_ and is always ready.
`include "sparse_polynomial_arith_assert.svh"
module sparse_polynomial_arith #(
   parameter int unsigned MAX_TERMS        = 8,
   parameter int unsigned MAX_RESULT_TERMS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operand_b,
   input  logic signed [15:0] req_term_coef,
   input  logic [7:0]         req_term_exponent,
   input  logic               req_last_term,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_result_coef,
   output logic [8:0]         rsp_result_exponent,
   output logic               rsp_result_last,
   output logic               rsp_result_empty,
   output logic               rsp_overflow,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_wdata
);
   import spa_pkg::*;

   spa_cmd_type  cmd;
   spa_stat_type stat;

   assign csr_ready  = 1'b1;
   assign rsp_strobe = cmd.emit;

   spa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   spa_datapath #(
      .MAX_TERMS        (MAX_TERMS),
      .MAX_RESULT_TERMS (MAX_RESULT_TERMS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_valid           (csr_valid),
      .csr_wdata           (csr_wdata),
      .req_operand_b       (req_operand_b),
      .req_term_coef       (req_term_coef),
      .req_term_exponent   (req_term_exponent),
      .req_last_term       (req_last_term),
      .rsp_result_coef     (rsp_result_coef),
      .rsp_result_exponent (rsp_result_exponent),
      .rsp_result_last     (rsp_result_last),
      .rsp_result_empty    (rsp_result_empty),
      .rsp_overflow        (rsp_overflow),
      .rsp_status          (rsp_status)
   );

   `SPA_ASSERT_NEVER(a_strobe_busy, clock, reset, rsp_strobe && !busy)
   `SPA_ASSERT(a_last_ends, clock, reset, (rsp_strobe && rsp_result_last) |=> !busy)
   `SPA_ASSERT(a_empty_last, clock, reset, (rsp_strobe && rsp_result_empty) |-> rsp_result_last)
   `SPA_ASSERT_NEVER(a_strobe_gap, clock, reset, rsp_strobe && $past(rsp_strobe))
endmodule
